@@ hw/rtl/sbed_pkg.sv @@
// ----------------------------------------------------------------------------
// sbed_pkg
// Shared types and codes for the sorted block entry decoder.
// ----------------------------------------------------------------------------
package sbed_pkg;

  // Result kinds
  localparam logic [1:0] KIND_HEADER  = 2'd0;
  localparam logic [1:0] KIND_KEY     = 2'd1;
  localparam logic [1:0] KIND_VALUE   = 2'd2;
  localparam logic [1:0] KIND_CORRUPT = 2'd3;

  // Decoder phases
  localparam logic [2:0] PH_SHARED  = 3'd0;
  localparam logic [2:0] PH_SUFFIX  = 3'd1;
  localparam logic [2:0] PH_VALUE   = 3'd2;
  localparam logic [2:0] PH_KEYBODY = 3'd3;
  localparam logic [2:0] PH_VALBODY = 3'd4;

  // Varint format
  localparam logic [7:0] CONT_BIT        = 8'd128;
  localparam logic [2:0] VARINT_LAST_IDX = 3'd4;  // fifth byte index

  // One result word
  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  byte_out;
    logic [31:0] position;
    logic [31:0] shared_len;
    logic [31:0] suffix_len;
    logic [31:0] value_len;
    logic        entry_end;
    logic        block_end;
  } res_t;

endpackage

@@ hw/rtl/sbed_in_if.sv @@
// ----------------------------------------------------------------------------
// sbed_in_if
// Byte channel into the decoder: one entry region byte per word.
// ----------------------------------------------------------------------------
interface sbed_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       region_end;

  modport source (output valid, output data_byte, output region_end, input ready);
  modport sink (input valid, input data_byte, input region_end, output ready);
endinterface

@@ hw/rtl/sbed_out_if.sv @@
// ----------------------------------------------------------------------------
// sbed_out_if
// Result channel out of the decoder: one header, key, value or corruption word.
// ----------------------------------------------------------------------------
interface sbed_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  byte_out;
  logic [31:0] position;
  logic [31:0] shared_len;
  logic [31:0] suffix_len;
  logic [31:0] value_len;
  logic        entry_end;
  logic        block_end;

  modport source (
    output valid, output kind, output byte_out, output position,
    output shared_len, output suffix_len, output value_len,
    output entry_end, output block_end, input ready
  );
  modport sink (
    input valid, input kind, input byte_out, input position,
    input shared_len, input suffix_len, input value_len,
    input entry_end, input block_end, output ready
  );
endinterface

@@ hw/rtl/sorted_block_entry_decoder.sv @@
// Decodes the entry region of a prefix-compressed sorted key-value block at
// one byte per cycle. Each byte is taken into an input register and then run
// through single-pass next-state logic (varint merge, 32-bit position add,
// saturating key-length add and shared-length compare) into a result
// register, from which its result is offered; a new byte is taken every cycle
// while results drain; a stalled result word holds the input register and
// drops entry_bytes.ready. Header bytes give no result until the value length
// completes; a corrupt block gives one corruption word and the rest of its
// bytes, up to region_end, are dropped.
// ----------------------------------------------------------------------------
// sorted_block_entry_decoder
// Streaming decoder for prefix-compressed block entries.
// ----------------------------------------------------------------------------
module sorted_block_entry_decoder
  import sbed_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  sbed_in_if.sink    entry_bytes,
  sbed_out_if.source results
);

  // Input register
  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_end;

  // Decoder state
  logic [2:0]  phase, phase_next;
  logic [31:0] varint_accum, varint_accum_next;
  logic [2:0]  varint_count, varint_count_next;
  logic [31:0] held_shared, held_shared_next;
  logic [31:0] held_suffix, held_suffix_next;
  logic [31:0] held_value, held_value_next;
  logic [31:0] body_count, body_count_next;
  logic [31:0] prev_key_len, prev_key_len_next;
  logic        error_seen, error_seen_next;

  // Result register
  logic out_valid;
  res_t out_res;

  logic advance;
  logic process;
  logic emit;
  res_t res;

  assign advance = !out_valid || results.ready;
  assign process = in_valid && advance;
  assign entry_bytes.ready = !in_valid || advance;

  // Input register load
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (entry_bytes.ready) begin
      in_valid <= entry_bytes.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (entry_bytes.ready && entry_bytes.valid) begin
      in_byte <= entry_bytes.data_byte;
      in_end  <= entry_bytes.region_end;
    end
  end

  // Varint merge of the current byte
  logic [31:0] varint_shifted;
  logic [31:0] varint_merged;

  always_comb begin
    unique case (varint_count)
      3'd0:    varint_shifted = {25'd0, in_byte[6:0]};
      3'd1:    varint_shifted = {18'd0, in_byte[6:0], 7'd0};
      3'd2:    varint_shifted = {11'd0, in_byte[6:0], 14'd0};
      3'd3:    varint_shifted = {4'd0, in_byte[6:0], 21'd0};
      default: varint_shifted = {in_byte[3:0], 28'd0};
    endcase
  end

  assign varint_merged = varint_accum | varint_shifted;

  // Body arithmetic
  logic [32:0] body_inc;
  logic [31:0] key_pos;
  logic [32:0] key_len_sum;
  logic [31:0] key_len_sat;

  assign body_inc    = {1'b0, body_count} + 33'd1;
  assign key_pos     = held_shared + body_count;
  assign key_len_sum = {1'b0, held_shared} + {1'b0, held_suffix};
  assign key_len_sat = key_len_sum[32] ? 32'hFFFF_FFFF : key_len_sum[31:0];

  // Next state and result
  always_comb begin
    logic corrupt;
    logic done;
    logic clear;

    corrupt = 1'b0;
    done    = 1'b0;
    clear   = 1'b0;
    emit    = 1'b0;

    phase_next        = phase;
    varint_accum_next = varint_accum;
    varint_count_next = varint_count;
    held_shared_next  = held_shared;
    held_suffix_next  = held_suffix;
    held_value_next   = held_value;
    body_count_next   = body_count;
    prev_key_len_next = prev_key_len;
    error_seen_next   = error_seen;

    res            = '0;
    res.shared_len = held_shared;
    res.suffix_len = held_suffix;
    res.value_len  = held_value;

    if (error_seen) begin
      // Dropping the rest of a corrupt block
      clear = in_end;
    end else begin
      unique case (phase)
        PH_SHARED, PH_SUFFIX, PH_VALUE: begin
          if ((in_byte & CONT_BIT) != 8'd0) begin
            // Varint continues
            if (varint_count == VARINT_LAST_IDX || in_end) begin
              corrupt = 1'b1;
            end else begin
              varint_accum_next = varint_merged;
              varint_count_next = varint_count + 3'd1;
            end
          end else begin
            varint_accum_next = '0;
            varint_count_next = '0;
            if (phase == PH_SHARED) begin
              held_shared_next = varint_merged;
              phase_next       = PH_SUFFIX;
              corrupt          = in_end;
            end else if (phase == PH_SUFFIX) begin
              held_suffix_next = varint_merged;
              phase_next       = PH_VALUE;
              corrupt          = in_end;
            end else begin
              // Value length complete: header record
              held_value_next = varint_merged;
              if (held_shared > prev_key_len) begin
                corrupt = 1'b1;
              end else begin
                prev_key_len_next = key_len_sat;
                body_count_next   = '0;
                done = (held_suffix == '0) && (varint_merged == '0);
                if (held_suffix != '0) begin
                  phase_next = PH_KEYBODY;
                end else if (varint_merged != '0) begin
                  phase_next = PH_VALBODY;
                end else begin
                  phase_next = PH_SHARED;
                end
                if (in_end && !done) begin
                  corrupt = 1'b1;
                end else begin
                  emit          = 1'b1;
                  res.kind      = KIND_HEADER;
                  res.value_len = varint_merged;
                  res.entry_end = done;
                  res.block_end = in_end;
                  clear         = in_end;
                end
              end
            end
          end
        end
        PH_KEYBODY: begin
          body_count_next = body_inc[31:0];
          if (body_inc >= {1'b0, held_suffix}) begin
            done            = (held_value == '0);
            phase_next      = (held_value != '0) ? PH_VALBODY : PH_SHARED;
            body_count_next = '0;
          end
          if (in_end && !done) begin
            corrupt = 1'b1;
          end else begin
            emit          = 1'b1;
            res.kind      = KIND_KEY;
            res.byte_out  = in_byte;
            res.position  = key_pos;
            res.entry_end = done;
            res.block_end = in_end;
            clear         = in_end;
          end
        end
        PH_VALBODY: begin
          body_count_next = body_inc[31:0];
          if (body_inc >= {1'b0, held_value}) begin
            done            = 1'b1;
            phase_next      = PH_SHARED;
            body_count_next = '0;
          end
          if (in_end && !done) begin
            corrupt = 1'b1;
          end else begin
            emit          = 1'b1;
            res.kind      = KIND_VALUE;
            res.byte_out  = in_byte;
            res.position  = body_count;
            res.entry_end = done;
            res.block_end = in_end;
            clear         = in_end;
          end
        end
        default: begin
          corrupt = 1'b1;
        end
      endcase

      if (corrupt) begin
        emit          = 1'b1;
        res           = '0;
        res.kind      = KIND_CORRUPT;
        res.block_end = 1'b1;
        clear         = 1'b1;
      end
    end

    // Block boundary or corruption returns state to reset; corruption before region_end sets error_seen
    if (clear) begin
      phase_next        = PH_SHARED;
      varint_accum_next = '0;
      varint_count_next = '0;
      held_shared_next  = '0;
      held_suffix_next  = '0;
      held_value_next   = '0;
      body_count_next   = '0;
      prev_key_len_next = '0;
      error_seen_next   = corrupt && !in_end;
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_SHARED;
      varint_accum <= '0;
      varint_count <= '0;
      held_shared  <= '0;
      held_suffix  <= '0;
      held_value   <= '0;
      body_count   <= '0;
      prev_key_len <= '0;
      error_seen   <= 1'b0;
    end else if (process) begin
      phase        <= phase_next;
      varint_accum <= varint_accum_next;
      varint_count <= varint_count_next;
      held_shared  <= held_shared_next;
      held_suffix  <= held_suffix_next;
      held_value   <= held_value_next;
      body_count   <= body_count_next;
      prev_key_len <= prev_key_len_next;
      error_seen   <= error_seen_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= process && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (process && emit) begin
      out_res <= res;
    end
  end

  assign results.valid      = out_valid;
  assign results.kind       = out_res.kind;
  assign results.byte_out   = out_res.byte_out;
  assign results.position   = out_res.position;
  assign results.shared_len = out_res.shared_len;
  assign results.suffix_len = out_res.suffix_len;
  assign results.value_len  = out_res.value_len;
  assign results.entry_end  = out_res.entry_end;
  assign results.block_end  = out_res.block_end;

  // Checks
  a_corrupt_ends_block: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_res.kind == KIND_CORRUPT |-> out_res.block_end && !out_res.entry_end)
    else $error("corruption word without block end");

  a_drop_state_clean: assert property (@(posedge clk) disable iff (rst)
    error_seen |-> phase == PH_SHARED && varint_count == 3'd0 && prev_key_len == '0)
    else $error("state not cleared while dropping a corrupt block");

  a_varint_bounded: assert property (@(posedge clk) disable iff (rst)
    varint_count <= VARINT_LAST_IDX)
    else $error("varint byte count past fifth byte");

  a_header_no_payload: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_res.kind == KIND_HEADER |-> out_res.byte_out == 8'd0
      && out_res.position == '0)
    else $error("header word carries byte or position");

  a_body_below_length: assert property (@(posedge clk) disable iff (rst)
    phase == PH_VALBODY |-> body_count < held_value)
    else $error("value byte count reached value length");

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the sorted block entry decoder. Entry regions are
// built byte by byte (clean entries, wide varints, corrupt and cut-off
// regions, noise) and streamed in with random bursts while the result side
// stalls on its own pattern. A predictor decodes every accepted byte and
// each result word is compared field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
  import sbed_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_BYTES = 1700;
  localparam int MAX_SHOWN = 40;

  logic clk;
  logic rst;

  sbed_in_if  byte_ch ();
  sbed_out_if result_ch ();

  sorted_block_entry_decoder DUT (
    .clk         (clk),
    .rst         (rst),
    .entry_bytes (byte_ch),
    .results     (result_ch)
  );

  // Predicted decoder state
  logic [2:0]  phase;
  logic [31:0] acc;
  logic [2:0]  vcount;
  logic [31:0] held_shared;
  logic [31:0] held_suffix;
  logic [31:0] held_value;
  logic [32:0] body;
  logic [31:0] prev_len;
  logic        dropping;

  res_t        pending_words[$];
  logic [7:0]  region_q[$];
  int unsigned bk_len;        // key length seen by the region builder
  int          burst_left;
  int          live_bytes;
  int          regions_sent;
  int          words_seen;
  int          errors;
  int          kind_count[4];
  int          cycle_count = 0;

  // Receiver stall pattern state
  int          rx_mode = 0;
  int          rx_mode_left = 0;
  int          rx_tick = 0;
  int          rx_run = 0;
  logic        rx_low = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words outstanding", cycle_count,
               pending_words.size());
      $display("simulation failed");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    errors++;
    if (errors <= MAX_SHOWN) $display("[%0t] MISMATCH: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("word %0d %s got %h want %h", words_seen, name, got,
                                want));
  endtask

  task automatic clear_decoder();
    phase       = PH_SHARED;
    acc         = '0;
    vcount      = '0;
    held_shared = '0;
    held_suffix = '0;
    held_value  = '0;
    body        = '0;
    prev_len    = '0;
    dropping    = 1'b0;
  endtask

  // Predict the result, if any, of one accepted byte
  task automatic decode_byte(input logic [7:0] b, input logic e);
    res_t        w;
    logic        bad;
    logic        put;
    logic        fin;
    logic        vdone;
    logic [31:0] v;
    logic [31:0] pos;
    logic [32:0] klen;
    w = '0;
    bad = 1'b0;
    put = 1'b0;
    fin = 1'b0;
    vdone = 1'b0;
    v = '0;
    if (dropping) begin
      if (e) clear_decoder();
      return;
    end
    live_bytes++;
    case (phase)
      PH_SHARED, PH_SUFFIX, PH_VALUE: begin
        // gather varint; a fifth byte with continuation is corrupt
        if (vcount > VARINT_LAST_IDX) begin
          bad = 1'b1;
        end else begin
          acc = acc | (32'(b[6:0]) << (7 * vcount));
          vcount = vcount + 3'd1;
          if ((b & CONT_BIT) != 0) begin
            bad = (vcount > VARINT_LAST_IDX);
          end else begin
            v = acc;
            acc = '0;
            vcount = '0;
            vdone = 1'b1;
          end
        end
        if (!bad && !vdone) begin
          bad = e;
        end else if (!bad) begin
          if (phase == PH_SHARED) begin
            held_shared = v;
            phase = PH_SUFFIX;
            bad = e;
          end else if (phase == PH_SUFFIX) begin
            held_suffix = v;
            phase = PH_VALUE;
            bad = e;
          end else begin
            held_value = v;
            if (held_shared > prev_len) begin
              bad = 1'b1;
            end else begin
              // full key length saturates at 32 bits
              klen = {1'b0, held_shared} + {1'b0, held_suffix};
              prev_len = klen[32] ? 32'hFFFF_FFFF : klen[31:0];
              body = '0;
              fin = (held_suffix == 0) && (held_value == 0);
              phase = (held_suffix != 0) ? PH_KEYBODY :
                      ((held_value != 0) ? PH_VALBODY : PH_SHARED);
              bad = e && !fin;
              w.kind = KIND_HEADER;
              put = 1'b1;
            end
          end
        end
      end
      PH_KEYBODY: begin
        pos = held_shared + body[31:0];
        body = body + 33'd1;
        if (body >= {1'b0, held_suffix}) begin
          fin = (held_value == 0);
          phase = (held_value != 0) ? PH_VALBODY : PH_SHARED;
          body = '0;
        end
        bad = e && !fin;
        w.kind = KIND_KEY;
        w.byte_out = b;
        w.position = pos;
        put = 1'b1;
      end
      PH_VALBODY: begin
        pos = body[31:0];
        body = body + 33'd1;
        if (body >= {1'b0, held_value}) begin
          fin = 1'b1;
          phase = PH_SHARED;
          body = '0;
        end
        bad = e && !fin;
        w.kind = KIND_VALUE;
        w.byte_out = b;
        w.position = pos;
        put = 1'b1;
      end
      default: bad = 1'b1;
    endcase

    if (bad) begin
      // one corruption word; rest of region dropped unless it ends here
      w = '0;
      w.kind = KIND_CORRUPT;
      w.block_end = 1'b1;
      pending_words.push_back(w);
      clear_decoder();
      dropping = !e;
    end else if (put) begin
      w.shared_len = held_shared;
      w.suffix_len = held_suffix;
      w.value_len  = held_value;
      w.entry_end  = fin;
      w.block_end  = e;
      pending_words.push_back(w);
      if (e) clear_decoder();
    end
  endtask

  // Send one byte, in bursts with random gaps
  task automatic send_byte(input logic [7:0] b, input logic e);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 6);
      byte_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(1, 30);
    end
    byte_ch.valid      <= 1'b1;
    byte_ch.data_byte  <= b;
    byte_ch.region_end <= e;
    do @(posedge clk); while (byte_ch.ready !== 1'b1);
    decode_byte(b, e);
    burst_left--;
  endtask

  // Stream the built region, flagging its last byte
  task automatic send_region();
    for (int i = 0; i < region_q.size(); i++)
      send_byte(region_q[i], i == region_q.size() - 1);
    regions_sent++;
    region_q.delete();
    bk_len = 0;
  endtask

  // Region builders
  task automatic put_varint(input logic [31:0] v, input int pad);
    int n;
    n = 1;
    while (n < 5 && (v >> (7 * n)) != 0) n++;
    n = n + pad;
    if (n > 5) n = 5;
    for (int i = 0; i < n; i++)
      region_q.push_back({i < n - 1, 7'(v >> (7 * i))});
  endtask

  function automatic int unsigned pick_len();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 80) return $urandom_range(0, 6);
    if (sel < 92) return $urandom_range(7, 20);
    return $urandom_range(128, 140);
  endfunction

  function automatic int pick_pad();
    return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : 0;
  endfunction

  task automatic add_entry(input int unsigned shared, input int unsigned suffix,
                           input int unsigned value);
    put_varint(shared, pick_pad());
    put_varint(suffix, pick_pad());
    put_varint(value, pick_pad());
    repeat (suffix) region_q.push_back(8'($urandom_range(0, 255)));
    repeat (value) region_q.push_back(8'($urandom_range(0, 255)));
    bk_len = shared + suffix;
  endtask

  task automatic add_good_entries(input int count);
    int unsigned shared;
    repeat (count) begin
      shared = (bk_len == 0) ? 0 : $urandom_range(0, bk_len);
      add_entry(shared, pick_len(), pick_len());
    end
  endtask

  task automatic add_noise(input int count);
    repeat (count) region_q.push_back(8'($urandom_range(0, 255)));
  endtask

  // ---- directed tests ----

  // two entries, second reusing a prefix, clean end
  task automatic test_clean_entries();
    region_q = '{8'h00, 8'h02, 8'h01, 8'hAA, 8'h55, 8'hFF,
                 8'h01, 8'h01, 8'h00, 8'h80};
    send_region();
  endtask

  // shared prefix longer than previous key, tail dropped
  task automatic test_shared_too_long();
    region_q = '{8'h03, 8'h00, 8'h00, 8'h7E};
    send_region();
  endtask

  // five continuation bytes, corruption on the region end byte itself
  task automatic test_overlong_varint();
    region_q = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
    send_region();
  endtask

  // region ends inside the headers
  task automatic test_truncated_region();
    region_q = '{8'h00, 8'h01};
    send_region();
  endtask

  // all-ones suffix length with high fifth-byte bits dropped, then cut off
  task automatic test_wide_lengths();
    region_q = '{8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h7F, 8'h00, 8'hFF};
    send_region();
  endtask

  // ---- random regions, mostly well formed ----
  task automatic test_random_regions();
    int sel;
    int cut;
    int target;
    target = live_bytes + RANDOM_BYTES;
    while (live_bytes < target) begin
      sel = $urandom_range(0, 99);
      if (sel < 65) begin
        add_good_entries($urandom_range(1, 5));
      end else if (sel < 74) begin
        add_good_entries($urandom_range(0, 2));
        add_entry(bk_len + $urandom_range(1, 4), $urandom_range(0, 3),
                  $urandom_range(0, 3));
        add_noise($urandom_range(0, 3));
      end else if (sel < 82) begin
        add_good_entries($urandom_range(0, 2));
        if ($urandom_range(0, 1) == 1) put_varint(0, 0);
        repeat (5) region_q.push_back({1'b1, 7'($urandom_range(0, 127))});
        add_noise($urandom_range(0, 3));
      end else if (sel < 94) begin
        add_good_entries($urandom_range(1, 4));
        cut = $urandom_range(1, region_q.size());
        while (region_q.size() > cut) void'(region_q.pop_back());
      end else begin
        add_noise($urandom_range(1, 12));
      end
      send_region();
    end
  endtask

  // Receiver: ready follows a changing stall pattern
  always @(posedge clk) begin
    rx_tick++;
    if (rx_mode_left == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_mode_left = $urandom_range(40, 250);
    end else begin
      rx_mode_left--;
    end
    case (rx_mode)
      0: result_ch.ready <= 1'b1;
      1: result_ch.ready <= 1'($urandom_range(0, 1));
      2: result_ch.ready <= (rx_tick % 3 == 0);
      default: begin
        if (rx_run == 0) begin
          rx_run = $urandom_range(1, 8);
          rx_low = !rx_low;
        end
        rx_run--;
        result_ch.ready <= !rx_low;
      end
    endcase
  end

  // Result checker
  always @(posedge clk) begin
    res_t want;
    res_t got;
    if (!rst && result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
      got.kind       = result_ch.kind;
      got.byte_out   = result_ch.byte_out;
      got.position   = result_ch.position;
      got.shared_len = result_ch.shared_len;
      got.suffix_len = result_ch.suffix_len;
      got.value_len  = result_ch.value_len;
      got.entry_end  = result_ch.entry_end;
      got.block_end  = result_ch.block_end;
      if (pending_words.size() == 0) begin
        report_mismatch($sformatf("unexpected word kind %0d", got.kind));
      end else begin
        want = pending_words.pop_front();
        check_field("kind", 32'(got.kind), 32'(want.kind));
        check_field("byte_out", 32'(got.byte_out), 32'(want.byte_out));
        check_field("position", got.position, want.position);
        check_field("shared_len", got.shared_len, want.shared_len);
        check_field("suffix_len", got.suffix_len, want.suffix_len);
        check_field("value_len", got.value_len, want.value_len);
        check_field("entry_end", 32'(got.entry_end), 32'(want.entry_end));
        check_field("block_end", 32'(got.block_end), 32'(want.block_end));
        kind_count[want.kind]++;
      end
      words_seen++;
    end
  end

  // Main sequence
  initial begin
    byte_ch.valid      <= 1'b0;
    byte_ch.data_byte  <= 8'h00;
    byte_ch.region_end <= 1'b0;
    rst                <= 1'b1;
    clear_decoder();
    burst_left = 0;
    live_bytes = 0;
    regions_sent = 0;
    words_seen = 0;
    errors = 0;
    kind_count = '{default: 0};
    bk_len = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_clean_entries();
    test_shared_too_long();
    test_overlong_varint();
    test_truncated_region();
    test_wide_lengths();
    test_random_regions();

    byte_ch.valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    if (pending_words.size() != 0)
      report_mismatch($sformatf("%0d words never arrived", pending_words.size()));

    $display("decoded %0d regions, %0d live bytes, %0d words checked",
             regions_sent, live_bytes, words_seen);
    $display("headers %0d, key bytes %0d, value bytes %0d, corruptions %0d, errors %0d",
             kind_count[KIND_HEADER], kind_count[KIND_KEY], kind_count[KIND_VALUE],
             kind_count[KIND_CORRUPT], errors);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
